// File: rtl/feic_pkg.sv
// Shared types and constants for the free extent insert and coalesce unit.
package feic_pkg;

    localparam int EXT_W       = 32;
    localparam int ENTRY_W     = 2 * EXT_W;
    localparam int STATUS_W    = 3;
    localparam int COUNT_OUT_W = 7;

    // Result codes reported with every item
    typedef enum logic [STATUS_W-1:0] {
        RES_FULL   = 3'd0,
        RES_NOFIT  = 3'd1,
        RES_NEW    = 3'd2,
        RES_EXTEND = 3'd3,
        RES_MERGE  = 3'd4
    } result_t;

    // Controller states
    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_LOAD_CHK,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_OPEN_CHK,
        S_OPEN_WR,
        S_CLOSE_CHK,
        S_CLOSE_WR,
        S_FINISH
    } ctl_state_t;

    // Datapath operations issued by the controller
    typedef enum logic [4:0] {
        OP_NONE,
        OP_LATCH_IN,
        OP_OPEN_FRONT,
        OP_READ_IDX,
        OP_LOAD_CUR,
        OP_READ_NEXT,
        OP_ADVANCE,
        OP_OPEN_AFTER,
        OP_WR_MERGE,
        OP_WR_EXT_END,
        OP_WR_EXT_START,
        OP_OPEN_READ,
        OP_OPEN_SHIFT,
        OP_OPEN_PUT,
        OP_CLOSE_READ,
        OP_CLOSE_SHIFT,
        OP_CLOSE_END,
        OP_EMIT
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t op;
        logic    set_code;
        result_t code;
    } feic_cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
        logic front_fit;
        logic last;
        logic gap_fit;
        logic touch_low;
        logic next_join;
        logic next_clear;
        logic touch_high;
        logic open_done;
        logic close_done;
        logic out_free;
    } feic_stat_t;

endpackage

// File: rtl/feic_ram.sv
// Generic single-write, single-read RAM with registered read data.
module feic_ram
#(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
)
(
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // Registered read port, hold when idle
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/feic_ctrl.sv
// Sequencer that steps the scan, shift and result transfer of one extent.
module feic_ctrl
    import feic_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  feic_stat_t stat,
    output feic_cmd_t  cmd
);

    ctl_state_t state_reg;
    ctl_state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (stat.full)
                begin
                    state_next = S_FINISH;
                end
                else if (stat.empty)
                begin
                    state_next = S_OPEN_CHK;
                end
                else
                begin
                    state_next = S_LOAD_CHK;
                end
            end
            S_LOAD_CHK:
            begin
                if (stat.front_fit)
                begin
                    state_next = S_OPEN_CHK;
                end
                else
                begin
                    state_next = S_SCAN_RD;
                end
            end
            S_SCAN_RD:
            begin
                state_next = S_SCAN_CHK;
            end
            S_SCAN_CHK:
            begin
                if (stat.gap_fit)
                begin
                    state_next = S_OPEN_CHK;
                end
                else if (stat.touch_low)
                begin
                    if (!stat.last && stat.next_join)
                    begin
                        state_next = S_CLOSE_CHK;
                    end
                    else
                    begin
                        state_next = S_FINISH;
                    end
                end
                else if (stat.touch_high || stat.last)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    state_next = S_SCAN_RD;
                end
            end
            S_OPEN_CHK:
            begin
                if (stat.open_done)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    state_next = S_OPEN_WR;
                end
            end
            S_OPEN_WR:
            begin
                state_next = S_OPEN_CHK;
            end
            S_CLOSE_CHK:
            begin
                if (stat.close_done)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    state_next = S_CLOSE_WR;
                end
            end
            S_CLOSE_WR:
            begin
                state_next = S_CLOSE_CHK;
            end
            S_FINISH:
            begin
                if (stat.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Outputs: datapath operation and result code
    always_comb
    begin
        cmd.op       = OP_NONE;
        cmd.set_code = 1'b0;
        cmd.code     = RES_NOFIT;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op = OP_LATCH_IN;
                end
            end
            S_CHECK:
            begin
                cmd.set_code = 1'b1;
                if (stat.full)
                begin
                    cmd.code = RES_FULL;
                end
                else if (stat.empty)
                begin
                    cmd.op   = OP_OPEN_FRONT;
                    cmd.code = RES_NEW;
                end
                else
                begin
                    cmd.op       = OP_READ_IDX;
                    cmd.set_code = 1'b0;
                end
            end
            S_LOAD_CHK:
            begin
                if (stat.front_fit)
                begin
                    cmd.op       = OP_OPEN_FRONT;
                    cmd.set_code = 1'b1;
                    cmd.code     = RES_NEW;
                end
                else
                begin
                    cmd.op = OP_LOAD_CUR;
                end
            end
            S_SCAN_RD:
            begin
                if (!stat.last)
                begin
                    cmd.op = OP_READ_NEXT;
                end
            end
            S_SCAN_CHK:
            begin
                cmd.set_code = 1'b1;
                if (stat.gap_fit)
                begin
                    cmd.op   = OP_OPEN_AFTER;
                    cmd.code = RES_NEW;
                end
                else if (stat.touch_low)
                begin
                    if (!stat.last && stat.next_join)
                    begin
                        cmd.op   = OP_WR_MERGE;
                        cmd.code = RES_MERGE;
                    end
                    else if (stat.last || stat.next_clear)
                    begin
                        cmd.op   = OP_WR_EXT_END;
                        cmd.code = RES_EXTEND;
                    end
                    else
                    begin
                        cmd.code = RES_NOFIT;
                    end
                end
                else if (stat.touch_high)
                begin
                    cmd.op   = OP_WR_EXT_START;
                    cmd.code = RES_EXTEND;
                end
                else if (stat.last)
                begin
                    cmd.code = RES_NOFIT;
                end
                else
                begin
                    cmd.op       = OP_ADVANCE;
                    cmd.set_code = 1'b0;
                end
            end
            S_OPEN_CHK:
            begin
                cmd.op = cmd_op_t'(stat.open_done ? OP_OPEN_PUT : OP_OPEN_READ);
            end
            S_OPEN_WR:
            begin
                cmd.op = OP_OPEN_SHIFT;
            end
            S_CLOSE_CHK:
            begin
                cmd.op = cmd_op_t'(stat.close_done ? OP_CLOSE_END : OP_CLOSE_READ);
            end
            S_CLOSE_WR:
            begin
                cmd.op = OP_CLOSE_SHIFT;
            end
            S_FINISH:
            begin
                if (stat.out_free)
                begin
                    cmd.op = OP_EMIT;
                end
            end
            default:
            begin
                cmd.op = OP_NONE;
            end
        endcase
    end

    assign in_stall = (state_reg != S_IDLE);

endmodule

// File: rtl/feic_datapath.sv
// Extent table, scan registers, compare logic and result register.
module feic_datapath
    import feic_pkg::*;
#(
    parameter int EXTENT_SLOTS = 64
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [EXT_W-1:0]       free_start,
    input  logic [EXT_W-1:0]       free_end,
    input  feic_cmd_t              cmd,
    output feic_stat_t             stat,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [STATUS_W-1:0]    status,
    output logic [COUNT_OUT_W-1:0] extent_count
);

    localparam int IW = $clog2(EXTENT_SLOTS);
    localparam int CW = $clog2(EXTENT_SLOTS + 1);

    // Control state
    logic [CW-1:0]          count_reg, count_next;
    logic                   out_valid_reg, out_valid_next;

    // Payload
    logic [EXT_W-1:0]       s_reg, s_next;
    logic [EXT_W-1:0]       e_reg, e_next;
    logic [EXT_W-1:0]       cur_start_reg, cur_start_next;
    logic [EXT_W-1:0]       cur_end_reg, cur_end_next;
    logic [IW-1:0]          idx_reg, idx_next;
    logic [IW-1:0]          ptr_reg, ptr_next;
    logic [IW-1:0]          pos_reg, pos_next;
    result_t                code_reg, code_next;
    logic [STATUS_W-1:0]    status_reg, status_next;
    logic [COUNT_OUT_W-1:0] ecount_reg, ecount_next;

    // Table port
    logic                   wr_en;
    logic [IW-1:0]          wr_addr;
    logic [ENTRY_W-1:0]     wr_data;
    logic                   rd_en;
    logic [IW-1:0]          rd_addr;
    logic [ENTRY_W-1:0]     rd_data;
    logic [EXT_W-1:0]       rd_start;
    logic [EXT_W-1:0]       rd_end;

    feic_ram
    #(
        .WIDTH (ENTRY_W),
        .DEPTH (EXTENT_SLOTS)
    )
    u_table
    (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign rd_start = rd_data[ENTRY_W-1:EXT_W];
    assign rd_end   = rd_data[EXT_W-1:0];

    // Status flags for the controller
    always_comb
    begin
        stat.full       = (count_reg >= CW'(EXTENT_SLOTS));
        stat.empty      = (count_reg == '0);
        stat.front_fit  = (s_reg < rd_start) && (e_reg < rd_start);
        stat.last       = ((CW'(idx_reg) + CW'(1)) >= count_reg);
        stat.gap_fit    = (s_reg > cur_end_reg) && (stat.last || (e_reg < rd_start));
        stat.touch_low  = (cur_end_reg == s_reg);
        stat.next_join  = (rd_start == e_reg);
        stat.next_clear = (rd_start > e_reg);
        stat.touch_high = (cur_start_reg == e_reg);
        stat.open_done  = (ptr_reg == pos_reg);
        stat.close_done = ((CW'(ptr_reg) + CW'(1)) >= count_reg);
        stat.out_free   = !out_valid_reg || !out_stall;
    end

    // Decode operation into register updates and table accesses
    always_comb
    begin
        count_next     = count_reg;
        out_valid_next = out_valid_reg;
        s_next         = s_reg;
        e_next         = e_reg;
        cur_start_next = cur_start_reg;
        cur_end_next   = cur_end_reg;
        idx_next       = idx_reg;
        ptr_next       = ptr_reg;
        pos_next       = pos_reg;
        code_next      = code_reg;
        status_next    = status_reg;
        ecount_next    = ecount_reg;
        wr_en          = 1'b0;
        wr_addr        = ptr_reg;
        wr_data        = rd_data;
        rd_en          = 1'b0;
        rd_addr        = idx_reg;

        // Drop the result once its transfer completes
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        if (cmd.set_code)
        begin
            code_next = cmd.code;
        end

        case (cmd.op)
            OP_LATCH_IN:
            begin
                s_next   = free_start;
                e_next   = free_end;
                idx_next = '0;
            end
            OP_OPEN_FRONT:
            begin
                pos_next = '0;
                ptr_next = IW'(count_reg);
            end
            OP_READ_IDX:
            begin
                rd_en   = 1'b1;
                rd_addr = idx_reg;
            end
            OP_LOAD_CUR:
            begin
                cur_start_next = rd_start;
                cur_end_next   = rd_end;
            end
            OP_READ_NEXT:
            begin
                rd_en   = 1'b1;
                rd_addr = idx_reg + IW'(1);
            end
            OP_ADVANCE:
            begin
                cur_start_next = rd_start;
                cur_end_next   = rd_end;
                idx_next       = idx_reg + IW'(1);
            end
            OP_OPEN_AFTER:
            begin
                pos_next = idx_reg + IW'(1);
                ptr_next = IW'(count_reg);
            end
            OP_WR_MERGE:
            begin
                wr_en    = 1'b1;
                wr_addr  = idx_reg;
                wr_data  = {cur_start_reg, rd_end};
                ptr_next = idx_reg + IW'(1);
            end
            OP_WR_EXT_END:
            begin
                wr_en   = 1'b1;
                wr_addr = idx_reg;
                wr_data = {cur_start_reg, e_reg};
            end
            OP_WR_EXT_START:
            begin
                wr_en   = 1'b1;
                wr_addr = idx_reg;
                wr_data = {s_reg, cur_end_reg};
            end
            OP_OPEN_READ:
            begin
                rd_en   = 1'b1;
                rd_addr = ptr_reg - IW'(1);
            end
            OP_OPEN_SHIFT:
            begin
                wr_en    = 1'b1;
                wr_addr  = ptr_reg;
                wr_data  = rd_data;
                ptr_next = ptr_reg - IW'(1);
            end
            OP_OPEN_PUT:
            begin
                wr_en      = 1'b1;
                wr_addr    = pos_reg;
                wr_data    = {s_reg, e_reg};
                count_next = count_reg + CW'(1);
            end
            OP_CLOSE_READ:
            begin
                rd_en   = 1'b1;
                rd_addr = ptr_reg + IW'(1);
            end
            OP_CLOSE_SHIFT:
            begin
                wr_en    = 1'b1;
                wr_addr  = ptr_reg;
                wr_data  = rd_data;
                ptr_next = ptr_reg + IW'(1);
            end
            OP_CLOSE_END:
            begin
                count_next = count_reg - CW'(1);
            end
            OP_EMIT:
            begin
                out_valid_next = 1'b1;
                status_next    = code_reg;
                ecount_next    = COUNT_OUT_W'(count_reg);
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        s_reg         <= s_next;
        e_reg         <= e_next;
        cur_start_reg <= cur_start_next;
        cur_end_reg   <= cur_end_next;
        idx_reg       <= idx_next;
        ptr_reg       <= ptr_next;
        pos_reg       <= pos_next;
        code_reg      <= code_next;
        status_reg    <= status_next;
        ecount_reg    <= ecount_next;
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign extent_count = ecount_reg;

endmodule

// File: rtl/free_extent_insert_coalesce_unit.sv
// A full table is rejected straight from the check state; otherwise the scan over the held
// extents and any shifting of entries come before the result. The one-read, one-write extent
// table sets this: the scan reads each further entry in a read state and checks it in a check
// state, and each entry moved by an insert or merge takes a read state and a write state.
// One extent at a time: in_stall stays high from the input transfer until the result is registered.
// Reset: rst_n clears the extent count and the result valid; table contents stay undefined.
module free_extent_insert_coalesce_unit
    import feic_pkg::*;
#(
    parameter int EXTENT_SLOTS = 64
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [EXT_W-1:0]       free_start,
    input  logic [EXT_W-1:0]       free_end,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [STATUS_W-1:0]    status,
    output logic [COUNT_OUT_W-1:0] extent_count
);

    feic_cmd_t  cmd;
    feic_stat_t stat;

    feic_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    feic_datapath
    #(
        .EXTENT_SLOTS (EXTENT_SLOTS)
    )
    u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .free_start   (free_start),
        .free_end     (free_end),
        .cmd          (cmd),
        .stat         (stat),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .extent_count (extent_count)
    );

    // Block goes busy right after taking an extent
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input not stalled after transfer");

    // A full rejection reports a full table
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == RES_FULL) |-> extent_count == COUNT_OUT_W'(EXTENT_SLOTS))
        else $error("full status with table not full");

    // Never place an entry into a full table
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_OPEN_PUT) |-> !stat.full)
        else $error("insert into full table");

    // Never overwrite a result still waiting for transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_EMIT) |-> stat.out_free)
        else $error("pending result overwritten");

endmodule
